### rtl/jihc_pkg.sv
// Shared types and constants of the joint index homing controller.
// Holds the phase codes, the register map, the micro-operation codes and
// the command and status structures used between controller and datapath.
`default_nettype none

package jihc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int PROD_W = 66;
   localparam int DIV_W = 48;
   localparam int INT_DIV = 2000;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [PROD_W-1:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT_MIN = -66'sd2147483648;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SEARCH = 3'd1,
      PH_HOLD   = 3'd2,
      PH_MOVE   = 3'd3,
      PH_FINISH = 3'd4,
      PH_FAULT  = 3'd5
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INV_GEAR_RATIO     = 3'd0,
      REG_CURRENT_PER_TORQUE = 3'd1,
      REG_REVERSE_POLARITY   = 3'd2,
      REG_MAX_CURRENT        = 3'd3,
      REG_MECHANICAL_MODE    = 3'd4,
      REG_ZERO_TO_INDEX      = 3'd5,
      REG_RAMP_TICKS         = 3'd6,
      REG_ZERO_TOLERANCE     = 3'd7
   } csr_reg_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MUL_POS, OP_MUL_VEL, OP_MUL_IDX, OP_MEAS, OP_ANG,
      OP_START, OP_VELERR, OP_MUL_DAMP, OP_TORQUE_S, OP_MUL_CUR, OP_DRIVE_S,
      OP_DRIVE_M, OP_INDEX, OP_ZERO, OP_HOLD, OP_MUL_RAMP, OP_DIV_RAMP, OP_DES,
      OP_MUL_INT, OP_INTEG, OP_MUL_P, OP_TORQUE_M, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic over;
      logic index_new;
      logic reached;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/joint_index_homing_controller.sv
// Top level of the joint index homing controller.
// Joins jihc_ctrl and jihc_dp; depends on jihc_pkg.
//
// One transaction is taken at a time; a result waiting in the output register
// does not stop the next transaction being accepted, but that transaction waits
// at its end for as long as the output stays stalled. A move tick forms its ramp
// target in the 48-step restoring divider, and the integrator step divides by a
// constant through a reciprocal multiplication. All multiplications share one
// 34 by 32 bit multiplier. Configuration writes are always ready.
`default_nettype none

module joint_index_homing_controller import jihc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_func,
   input  wire logic signed [31:0]    req_motor_position,
   input  wire logic signed [31:0]    req_motor_velocity,
   input  wire logic signed [31:0]    req_index_stamp,
   input  wire logic signed [31:0]    req_index_position,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [31:0]         rsp_current_target,
   output logic [2:0]                 rsp_phase,
   output logic signed [31:0]         rsp_zero_angle_out,
   output logic signed [31:0]         rsp_index_angle_out,
   output logic signed [31:0]         rsp_zero_to_index_out,
   output logic signed [31:0]         rsp_final_error,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]           csr_data
);

   cmd_type cmd;
   status_type status;

   assign csr_ready = 1'b1;

   jihc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_phase (rsp_phase),
      .cmd       (cmd),
      .status    (status)
   );

   jihc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_motor_position    (req_motor_position),
      .req_motor_velocity    (req_motor_velocity),
      .req_index_stamp       (req_index_stamp),
      .req_index_position    (req_index_position),
      .cmd                   (cmd),
      .status                (status),
      .rsp_current_target    (rsp_current_target),
      .rsp_zero_angle_out    (rsp_zero_angle_out),
      .rsp_index_angle_out   (rsp_index_angle_out),
      .rsp_zero_to_index_out (rsp_zero_to_index_out),
      .rsp_final_error       (rsp_final_error)
   );

endmodule

`default_nettype wire

### rtl/jihc_dp.sv
// Datapath of the joint index homing controller: configuration registers,
// homing state, one shared multiplier and a restoring divider for the ramp.
// Depends on jihc_pkg; driven by micro-operations from jihc_ctrl.
`default_nettype none

module jihc_dp import jihc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]           csr_data,
   input  wire logic signed [31:0]    req_motor_position,
   input  wire logic signed [31:0]    req_motor_velocity,
   input  wire logic signed [31:0]    req_index_stamp,
   input  wire logic signed [31:0]    req_index_position,
   input  wire cmd_type               cmd,
   output status_type                 status,
   output logic signed [31:0]         rsp_current_target,
   output logic signed [31:0]         rsp_zero_angle_out,
   output logic signed [31:0]         rsp_index_angle_out,
   output logic signed [31:0]         rsp_zero_to_index_out,
   output logic signed [31:0]         rsp_final_error
);

   localparam int RW = PROD_W - FRAC_BITS;
   localparam longint QONE = longint'(1) << FRAC_BITS;
   localparam longint QHALF = QONE / 2;
   localparam longint GAIN_D = (2 * QONE + 5) / 10;
   localparam longint VEL_DES = (8 * QONE + 5) / 10;
   localparam longint GAIN_P = (5 * QONE) / 2;
   localparam longint INT_SAT = (QONE + 5) / 10;
   localparam int IW = $clog2(INT_SAT + 1) + 1;
   localparam int CW = $clog2(DIV_W + 1);
   localparam int INT_PRE = 4;
   localparam int INT_SHIFT = 37;
   localparam longint INT_ODD = INT_DIV / (1 << INT_PRE);
   localparam longint INT_RECIP = ((longint'(1) << INT_SHIFT) + INT_ODD - 1) / INT_ODD;

   logic [30:0] inv_ff, cpt_ff, maxc_ff, tol_ff;
   logic pol_ff, mech_ff;
   logic signed [31:0] zoff_ff;
   logic [15:0] rt_ff;

   logic signed [31:0] pos_ff, vel_ff, stamp_ff, idxpos_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [31:0] meas_ff, ang_ff, tsat_ff;
   logic signed [33:0] d_ff;

   logic signed [31:0] zero_ff, start_ff, last_ff, index_ff, offset_ff, ramp_ff;
   logic signed [31:0] final_ff, cur_ff;
   logic [15:0] tick_ff;
   logic signed [IW-1:0] integ_ff;

   logic [15:0] rem_ff, dsor_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;
   logic neg_ff;

   logic signed [32:0] pos_p, vel_p, idx_p;
   logic signed [33:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [PROD_W-1:0] mul_p, rsum;
   logic signed [RW-1:0] rnd, c_mag;
   logic [15:0] tt, cnt_c;
   logic [16:0] span, trial, tick_nx;
   logic signed [31:0] rs;
   logic [PROD_W-1:0] prod_mag;
   logic [33:0] d_mag, int_num, iq;
   logic signed [DIV_W:0] q_s;
   logic signed [33:0] des, isum, istep;
   logic signed [32:0] ang_mag;
   logic signed [31:0] cur32;

   assign pos_p = pol_ff ? -(33'(pos_ff)) : 33'(pos_ff);
   assign vel_p = pol_ff ? -(33'(vel_ff)) : 33'(vel_ff);
   assign idx_p = pol_ff ? -(33'(idxpos_ff)) : 33'(idxpos_ff);

   assign tt = (rt_ff == 16'd0) ? 16'd1 : rt_ff;
   assign cnt_c = (tick_ff > tt) ? tt : tick_ff;
   assign span = {1'b0, tt} - {1'b0, cnt_c};
   assign rs = (tick_ff == 16'd0) ? ang_ff : ramp_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_MUL_POS: begin
            mul_a = 34'(pos_p);
            mul_b = $signed({1'b0, inv_ff});
         end
         OP_MUL_VEL: begin
            mul_a = 34'(vel_p);
            mul_b = $signed({1'b0, inv_ff});
         end
         OP_MUL_IDX: begin
            mul_a = 34'(idx_p);
            mul_b = $signed({1'b0, inv_ff});
         end
         OP_MUL_DAMP: begin
            mul_a = d_ff;
            mul_b = 32'(GAIN_D);
         end
         OP_MUL_CUR: begin
            mul_a = 34'(tsat_ff);
            mul_b = $signed({1'b0, cpt_ff});
         end
         OP_MUL_RAMP: begin
            mul_a = 34'(rs);
            mul_b = $signed({15'd0, span});
         end
         OP_MUL_INT: begin
            mul_a = $signed({4'd0, int_num[33:INT_PRE]});
            mul_b = 32'(INT_RECIP);
         end
         OP_MUL_P: begin
            mul_a = d_ff;
            mul_b = 32'(GAIN_P);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign rsum = prod_ff + PROD_W'(QHALF);
   assign rnd = RW'(rsum >>> FRAC_BITS);
   assign c_mag = rnd[RW-1] ? -rnd : rnd;
   assign cur32 = rnd[31:0];
   assign prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign d_mag = d_ff[33] ? 34'(-d_ff) : 34'(d_ff);
   assign int_num = d_mag + 34'(INT_DIV / 2);
   assign iq = 34'(prod_ff[PROD_W-1:INT_SHIFT]);
   assign istep = neg_ff ? -$signed(iq) : $signed(iq);
   assign q_s = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign des = 34'(q_s);
   assign isum = 34'(integ_ff) + istep;
   assign ang_mag = ang_ff[31] ? -(33'(ang_ff)) : 33'(ang_ff);
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign tick_nx = {1'b0, tick_ff} + 17'd1;

   assign status.div_done = (cnt_ff == '0);
   assign status.over = c_mag > RW'({1'b0, maxc_ff});
   assign status.index_new = stamp_ff > last_ff;
   assign status.reached = ang_mag <= $signed({2'b00, tol_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 31'd65536;
         cpt_ff <= 31'd65536;
         pol_ff <= 1'b0;
         maxc_ff <= 31'd786432;
         mech_ff <= 1'b1;
         zoff_ff <= '0;
         rt_ff <= 16'd2000;
         tol_ff <= 31'd655;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_INV_GEAR_RATIO:     inv_ff <= csr_data[30:0];
            REG_CURRENT_PER_TORQUE: cpt_ff <= csr_data[30:0];
            REG_REVERSE_POLARITY:   pol_ff <= csr_data[0];
            REG_MAX_CURRENT:        maxc_ff <= csr_data[30:0];
            REG_MECHANICAL_MODE:    mech_ff <= csr_data[0];
            REG_ZERO_TO_INDEX:      zoff_ff <= $signed(csr_data);
            REG_RAMP_TICKS:         rt_ff <= csr_data[15:0];
            REG_ZERO_TOLERANCE:     tol_ff <= csr_data[30:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= '0;
         start_ff <= '0;
         last_ff <= -32'sd1;
         index_ff <= '0;
         offset_ff <= '0;
         ramp_ff <= '0;
         tick_ff <= '0;
         integ_ff <= '0;
         final_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (trial >= {1'b0, dsor_ff}) begin
               rem_ff <= 16'(trial - {1'b0, dsor_ff});
               quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[15:0];
               quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
            end
         end
         unique case (cmd.op)
            OP_LOAD: begin
               pos_ff <= req_motor_position;
               vel_ff <= req_motor_velocity;
               stamp_ff <= req_index_stamp;
               idxpos_ff <= req_index_position;
               cur_ff <= '0;
            end
            OP_MUL_POS, OP_MUL_VEL, OP_MUL_IDX, OP_MUL_DAMP, OP_MUL_CUR, OP_MUL_P: begin
               prod_ff <= mul_p;
            end
            OP_MUL_RAMP: begin
               prod_ff <= mul_p;
               ramp_ff <= rs;
            end
            OP_MEAS: meas_ff <= sat32(PROD_W'(rnd));
            OP_ANG: ang_ff <= sat32(PROD_W'(meas_ff) - PROD_W'(zero_ff));
            OP_START: begin
               start_ff <= ang_ff;
               zero_ff <= '0;
               index_ff <= '0;
               final_ff <= '0;
               last_ff <= stamp_ff;
            end
            OP_VELERR: d_ff <= 34'(VEL_DES) - 34'(meas_ff);
            OP_TORQUE_S: tsat_ff <= sat32(PROD_W'(rnd));
            OP_TORQUE_M: tsat_ff <= sat32(PROD_W'(rnd) + PROD_W'(integ_ff));
            OP_DRIVE_S: begin
               if (!status.over) begin
                  cur_ff <= pol_ff ? -cur32 : cur32;
               end
            end
            OP_DRIVE_M: begin
               if (!status.over) begin
                  cur_ff <= pol_ff ? -cur32 : cur32;
                  if (status.reached) begin
                     final_ff <= sat32(-PROD_W'(d_ff));
                  end
                  tick_ff <= (tick_nx > {1'b0, tt}) ? tt : tick_nx[15:0];
               end
            end
            OP_INDEX: begin
               index_ff <= meas_ff;
               offset_ff <= mech_ff ? sat32(PROD_W'(meas_ff) - PROD_W'(start_ff)) : zoff_ff;
            end
            OP_ZERO: zero_ff <= sat32(PROD_W'(index_ff) - PROD_W'(offset_ff));
            OP_HOLD: begin
               integ_ff <= '0;
               tick_ff <= '0;
            end
            OP_DIV_RAMP: begin
               rem_ff <= '0;
               quo_ff <= prod_mag[DIV_W-1:0] + DIV_W'(tt >> 1);
               dsor_ff <= tt;
               neg_ff <= prod_ff[PROD_W-1];
               cnt_ff <= CW'(DIV_W);
            end
            OP_DES: d_ff <= des - 34'(ang_ff);
            OP_MUL_INT: begin
               prod_ff <= mul_p;
               neg_ff <= d_ff[33];
            end
            OP_INTEG: begin
               if (isum > 34'(INT_SAT)) begin
                  integ_ff <= IW'(INT_SAT);
               end else if (isum < -34'(INT_SAT)) begin
                  integ_ff <= IW'(-INT_SAT);
               end else begin
                  integ_ff <= IW'(isum);
               end
            end
            OP_OUT: begin
               rsp_current_target <= cur_ff;
               rsp_zero_angle_out <= zero_ff;
               rsp_index_angle_out <= index_ff;
               rsp_zero_to_index_out <= offset_ff;
               rsp_final_error <= final_ff;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/jihc_ctrl.sv
// Sequencing state machine of the joint index homing controller.
// Holds the homing phase and the handshakes, and issues micro-operations
// to jihc_dp; depends on jihc_pkg.
`default_nettype none

module jihc_ctrl import jihc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_func,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_phase,
   output cmd_type          cmd,
   input  wire status_type  status
);

   typedef enum logic [25:0] {
      ST_IDLE      = 26'b1 << 0,
      ST_MUL_POS   = 26'b1 << 1,
      ST_MEAS_POS  = 26'b1 << 2,
      ST_ANG       = 26'b1 << 3,
      ST_START     = 26'b1 << 4,
      ST_MUL_VEL   = 26'b1 << 5,
      ST_MEAS_VEL  = 26'b1 << 6,
      ST_VELERR    = 26'b1 << 7,
      ST_MUL_DAMP  = 26'b1 << 8,
      ST_TORQUE_S  = 26'b1 << 9,
      ST_MUL_CUR   = 26'b1 << 10,
      ST_DRIVE     = 26'b1 << 11,
      ST_MUL_IDX   = 26'b1 << 12,
      ST_MEAS_IDX  = 26'b1 << 13,
      ST_INDEX     = 26'b1 << 14,
      ST_ZERO      = 26'b1 << 15,
      ST_HOLD      = 26'b1 << 16,
      ST_MUL_RAMP  = 26'b1 << 17,
      ST_DIV_RAMP  = 26'b1 << 18,
      ST_WAIT_RAMP = 26'b1 << 19,
      ST_DES       = 26'b1 << 20,
      ST_MUL_INT   = 26'b1 << 21,
      ST_INTEG     = 26'b1 << 22,
      ST_MUL_P     = 26'b1 << 23,
      ST_TORQUE_M  = 26'b1 << 24,
      ST_DONE      = 26'b1 << 25
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic start_ff, start_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_phase_ff, rsp_phase_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_phase = rsp_phase_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               start_in = 1'b0;
               if (phase_ff == PH_FAULT) begin
                  state_in = ST_DONE;
               end else if (req_func) begin
                  start_in = 1'b1;
                  state_in = ST_MUL_POS;
               end else if (phase_ff == PH_SEARCH) begin
                  state_in = ST_MUL_VEL;
               end else if (phase_ff == PH_HOLD) begin
                  state_in = ST_HOLD;
               end else if (phase_ff == PH_MOVE) begin
                  state_in = ST_MUL_POS;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL_POS: begin
            cmd.op = OP_MUL_POS;
            state_in = ST_MEAS_POS;
         end
         ST_MEAS_POS: begin
            cmd.op = OP_MEAS;
            state_in = ST_ANG;
         end
         ST_ANG: begin
            cmd.op = OP_ANG;
            state_in = start_ff ? ST_START : ST_MUL_RAMP;
         end
         ST_START: begin
            cmd.op = OP_START;
            phase_in = PH_SEARCH;
            state_in = ST_DONE;
         end
         ST_MUL_VEL: begin
            cmd.op = OP_MUL_VEL;
            state_in = ST_MEAS_VEL;
         end
         ST_MEAS_VEL: begin
            cmd.op = OP_MEAS;
            state_in = ST_VELERR;
         end
         ST_VELERR: begin
            cmd.op = OP_VELERR;
            state_in = ST_MUL_DAMP;
         end
         ST_MUL_DAMP: begin
            cmd.op = OP_MUL_DAMP;
            state_in = ST_TORQUE_S;
         end
         ST_TORQUE_S: begin
            cmd.op = OP_TORQUE_S;
            state_in = ST_MUL_CUR;
         end
         ST_MUL_CUR: begin
            cmd.op = OP_MUL_CUR;
            state_in = ST_DRIVE;
         end
         ST_DRIVE: begin
            cmd.op = (phase_ff == PH_MOVE) ? OP_DRIVE_M : OP_DRIVE_S;
            state_in = ST_DONE;
            if (status.over) begin
               phase_in = PH_FAULT;
            end else if (phase_ff == PH_MOVE) begin
               if (status.reached) begin
                  phase_in = PH_FINISH;
               end
            end else if (status.index_new) begin
               state_in = ST_MUL_IDX;
            end
         end
         ST_MUL_IDX: begin
            cmd.op = OP_MUL_IDX;
            state_in = ST_MEAS_IDX;
         end
         ST_MEAS_IDX: begin
            cmd.op = OP_MEAS;
            state_in = ST_INDEX;
         end
         ST_INDEX: begin
            cmd.op = OP_INDEX;
            state_in = ST_ZERO;
         end
         ST_ZERO: begin
            cmd.op = OP_ZERO;
            phase_in = PH_HOLD;
            state_in = ST_DONE;
         end
         ST_HOLD: begin
            cmd.op = OP_HOLD;
            phase_in = PH_MOVE;
            state_in = ST_DONE;
         end
         ST_MUL_RAMP: begin
            cmd.op = OP_MUL_RAMP;
            state_in = ST_DIV_RAMP;
         end
         ST_DIV_RAMP: begin
            cmd.op = OP_DIV_RAMP;
            state_in = ST_WAIT_RAMP;
         end
         ST_WAIT_RAMP: begin
            if (status.div_done) begin
               state_in = ST_DES;
            end
         end
         ST_DES: begin
            cmd.op = OP_DES;
            state_in = ST_MUL_INT;
         end
         ST_MUL_INT: begin
            cmd.op = OP_MUL_INT;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.op = OP_INTEG;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.op = OP_MUL_P;
            state_in = ST_TORQUE_M;
         end
         ST_TORQUE_M: begin
            cmd.op = OP_TORQUE_M;
            state_in = ST_MUL_CUR;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.op = OP_OUT;
               rsp_valid_in = 1'b1;
               rsp_phase_in = phase_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_phase_ff <= PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_phase_ff <= rsp_phase_in;
      end
   end

endmodule

`default_nettype wire

### rtl/jihc_checker.sv
// Port-level checker of the joint index homing controller and its bind.
// Depends on jihc_pkg; watches the top-level ports only.
`default_nettype none

module jihc_checker import jihc_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_current_target,
   input wire logic [2:0]         rsp_phase
);

   logic fault_seen_ff, fault_seen_in;

   assign fault_seen_in = fault_seen_ff ||
                          (rsp_valid && !rsp_stall && rsp_phase == PH_FAULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_seen_ff <= 1'b0;
      end else begin
         fault_seen_ff <= fault_seen_in;
      end
   end

   // Fault is sticky until reset.
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fault_seen_ff |-> rsp_phase == PH_FAULT)
      else $error("phase left fault");

   // No current is commanded in fault or idle.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_FAULT |-> rsp_current_target == 32'sd0)
      else $error("current in fault");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_IDLE |-> rsp_current_target == 32'sd0)
      else $error("current in idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_current_target))
      else $error("stalled transaction changed");

endmodule

bind joint_index_homing_controller jihc_checker u_jihc_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for joint_index_homing_controller.
// Holds a scoreboard class with its own fixed-point model of the homing sequence, tasks for
// requests and configuration writes and a stall process; depends on jihc_pkg and the DUT.
`default_nettype none

module tb;
   import jihc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint GAIN_D = 13107;
   localparam longint VEL_DES = 52429;
   localparam longint GAIN_P = 163840;
   localparam longint INT_SAT = 6554;
   localparam longint HALF_LSB = 32768;
   localparam int SETTLE_CYCLES = 150;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      bit                 func;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] stamp;
      logic signed [31:0] index_pos;
   } homing_item_type;

   typedef struct {
      logic signed [31:0] current;
      logic [2:0]         phase;
      logic signed [31:0] zero;
      logic signed [31:0] index;
      logic signed [31:0] offset;
      logic signed [31:0] final_err;
   } homing_result_type;

   class homing_scoreboard_type;
      longint inv_gear, amps_per_torque, max_amps, zero_tol, offset_cfg;
      bit reversed, mechanical;
      int ramp_len;
      phase_type phase;
      longint zero_point, start_angle, last_stamp, index_point, offset_used;
      longint ramp_start, integ, final_err;
      int tick_count;
      homing_result_type expected_q[$];
      int errors;

      function new();
         inv_gear = 65536; amps_per_torque = 65536; reversed = 0; max_amps = 786432;
         mechanical = 1; offset_cfg = 0; ramp_len = 2000; zero_tol = 655;
         phase = PH_IDLE;
         zero_point = 0; start_angle = 0; last_stamp = -1; index_point = 0;
         offset_used = 0; ramp_start = 0; tick_count = 0; integ = 0; final_err = 0;
         errors = 0;
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint round_div(longint n, longint d);
         if (n >= 0) return (n + d / 2) / d;
         return -((-n + d / 2) / d);
      endfunction

      function longint joint_value(logic signed [31:0] raw);
         longint p;
         p = raw;
         if (reversed) p = -p;
         return sat((p * inv_gear + HALF_LSB) >>> 16);
      endfunction

      function bit torque_to_current(longint torque, output longint cur);
         longint c, mag;
         c = (sat(torque) * amps_per_torque + HALF_LSB) >>> 16;
         mag = c < 0 ? -c : c;
         cur = 0;
         if (mag > max_amps) return 0;
         cur = reversed ? -c : c;
         return 1;
      endfunction

      function void write_reg(csr_reg_type idx, logic [31:0] d);
         case (idx)
            REG_INV_GEAR_RATIO: begin
               inv_gear = d[30:0];
            end
            REG_CURRENT_PER_TORQUE: begin
               amps_per_torque = d[30:0];
            end
            REG_REVERSE_POLARITY: begin
               reversed = d[0];
            end
            REG_MAX_CURRENT: begin
               max_amps = d[30:0];
            end
            REG_MECHANICAL_MODE: begin
               mechanical = d[0];
            end
            REG_ZERO_TO_INDEX: begin
               offset_cfg = $signed(d);
            end
            REG_RAMP_TICKS: begin
               ramp_len = d[15:0];
            end
            REG_ZERO_TOLERANCE: begin
               zero_tol = d[30:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void note_item(homing_item_type it);
         longint cur, ang, t, err, des, c, tt;
         homing_result_type r;
         cur = 0;
         if (phase == PH_FAULT) begin
         end else if (it.func) begin
            start_angle = sat(joint_value(it.position) - zero_point);
            zero_point = 0;
            index_point = 0;
            final_err = 0;
            last_stamp = it.stamp;
            phase = PH_SEARCH;
         end else if (phase == PH_SEARCH) begin
            t = (GAIN_D * (VEL_DES - joint_value(it.velocity)) + HALF_LSB) >>> 16;
            if (!torque_to_current(t, cur)) begin
               cur = 0;
               phase = PH_FAULT;
            end else if (longint'(it.stamp) > last_stamp) begin
               index_point = joint_value(it.index_pos);
               offset_used = mechanical ? sat(index_point - start_angle) : offset_cfg;
               zero_point = sat(index_point - offset_used);
               phase = PH_HOLD;
            end
         end else if (phase == PH_HOLD) begin
            integ = 0;
            tick_count = 0;
            phase = PH_MOVE;
         end else if (phase == PH_MOVE) begin
            ang = sat(joint_value(it.position) - zero_point);
            if (tick_count == 0) ramp_start = ang;
            tt = ramp_len != 0 ? ramp_len : 1;
            c = tick_count > tt ? tt : tick_count;
            des = round_div(ramp_start * (tt - c), tt);
            err = des - ang;
            integ += round_div(err, INT_DIV);
            if (integ > INT_SAT) integ = INT_SAT;
            if (integ < -INT_SAT) integ = -INT_SAT;
            t = ((GAIN_P * err + HALF_LSB) >>> 16) + integ;
            if (!torque_to_current(t, cur)) begin
               cur = 0;
               phase = PH_FAULT;
            end else begin
               if ((ang < 0 ? -ang : ang) <= zero_tol) begin
                  final_err = sat(-err);
                  phase = PH_FINISH;
               end
               c = tick_count + 1;
               tick_count = int'(c > tt ? tt : c);
            end
         end
         r.current = cur[31:0];
         r.phase = phase;
         r.zero = zero_point[31:0];
         r.index = index_point[31:0];
         r.offset = offset_used[31:0];
         r.final_err = final_err[31:0];
         expected_q.push_back(r);
      endfunction

      function void check_result(homing_result_type got);
         homing_result_type e;
         if (expected_q.size() == 0) begin
            $error("response received with no transaction outstanding");
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.current !== e.current) begin
            $error("current_target: expected %0d, got %0d", e.current, got.current);
            errors++;
         end
         if (got.phase !== e.phase) begin
            $error("phase: expected %0d, got %0d", e.phase, got.phase);
            errors++;
         end
         if (got.zero !== e.zero) begin
            $error("zero_angle_out: expected %0d, got %0d", e.zero, got.zero);
            errors++;
         end
         if (got.index !== e.index) begin
            $error("index_angle_out: expected %0d, got %0d", e.index, got.index);
            errors++;
         end
         if (got.offset !== e.offset) begin
            $error("zero_to_index_out: expected %0d, got %0d", e.offset, got.offset);
            errors++;
         end
         if (got.final_err !== e.final_err) begin
            $error("final_error: expected %0d, got %0d", e.final_err, got.final_err);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = 1'b0;
   logic signed [31:0] req_motor_position = '0;
   logic signed [31:0] req_motor_velocity = '0;
   logic signed [31:0] req_index_stamp = '0;
   logic signed [31:0] req_index_position = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_current_target;
   logic [2:0] rsp_phase;
   logic signed [31:0] rsp_zero_angle_out;
   logic signed [31:0] rsp_index_angle_out;
   logic signed [31:0] rsp_zero_to_index_out;
   logic signed [31:0] rsp_final_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   homing_scoreboard_type sb = new();
   int items_sent = 0;
   int burst_left = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   logic [8:0] stall_phase = '0;
   int idle_cycles = 0;

   joint_index_homing_controller uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_motor_position(req_motor_position), .req_motor_velocity(req_motor_velocity),
      .req_index_stamp(req_index_stamp), .req_index_position(req_index_position),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_current_target(rsp_current_target), .rsp_phase(rsp_phase),
      .rsp_zero_angle_out(rsp_zero_angle_out), .rsp_index_angle_out(rsp_index_angle_out),
      .rsp_zero_to_index_out(rsp_zero_to_index_out), .rsp_final_error(rsp_final_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // The receiver stalls at random in the second half of each window, and once holds off
   // for a long stretch so that the block fills up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && items_sent >= 400) begin
         long_hold_done <= 1'b1;
         hold_left <= 600;
         rsp_stall <= 1'b1;
      end else begin
         stall_phase <= stall_phase + 1;
         rsp_stall <= stall_phase[8] ? ($urandom_range(0, 2) == 0) : 1'b0;
      end
   end

   always @(posedge clock) begin
      homing_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.current = rsp_current_target;
         got.phase = rsp_phase;
         got.zero = rsp_zero_angle_out;
         got.index = rsp_index_angle_out;
         got.offset = rsp_zero_to_index_out;
         got.final_err = rsp_final_error;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [31:0] rnd_span(int b);
      return $signed($urandom_range(0, 2 * b)) - b;
   endfunction

   // Raw motor position that measures as the given joint angle under the current setting.
   function automatic logic signed [31:0] raw_for_angle(longint a);
      longint v;
      v = sb.sat(a + sb.zero_point);
      if (sb.inv_gear != 65536) v = v * 65536 / sb.inv_gear;
      if (sb.reversed) v = -v;
      v = sb.sat(v);
      return v[31:0];
   endfunction

   task automatic send_item(homing_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_motor_position <= it.position;
      req_motor_velocity <= it.velocity;
      req_index_stamp <= it.stamp;
      req_index_position <= it.index_pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(it);
      items_sent++;
      burst_left--;
   endtask

   task automatic send(bit func, logic signed [31:0] pos, logic signed [31:0] vel,
                       logic signed [31:0] stamp, logic signed [31:0] ipos);
      homing_item_type it;
      it.func = func;
      it.position = pos;
      it.velocity = vel;
      it.stamp = stamp;
      it.index_pos = ipos;
      send_item(it);
   endtask

   task automatic send_noise(bit full_range);
      if (full_range) begin
         send($urandom_range(0, 3) == 0, $urandom, $urandom, $urandom, $urandom);
      end else begin
         send($urandom_range(0, 9) == 0, rnd_span(1 << 20), rnd_span(1 << 16),
              $signed($urandom_range(0, 2000)) - 1, rnd_span(1 << 20));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic cfg_write(csr_reg_type idx, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, d);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] inv, logic [31:0] cpt, logic [31:0] rev,
                            logic [31:0] maxc, logic [31:0] mech, logic [31:0] off,
                            logic [31:0] ramp, logic [31:0] tol);
      cfg_write(REG_INV_GEAR_RATIO, inv);
      cfg_write(REG_CURRENT_PER_TORQUE, cpt);
      cfg_write(REG_REVERSE_POLARITY, rev);
      cfg_write(REG_MAX_CURRENT, maxc);
      cfg_write(REG_MECHANICAL_MODE, mech);
      cfg_write(REG_ZERO_TO_INDEX, off);
      cfg_write(REG_RAMP_TICKS, ramp);
      cfg_write(REG_ZERO_TOLERANCE, tol);
   endtask

   // Move ticks follow the ramp with a little noise, then settle near zero.
   task automatic track_ramp(int max_ticks);
      longint a0, a, tt;
      int k;
      a0 = rnd_span(1 << 18);
      tt = sb.ramp_len != 0 ? sb.ramp_len : 1;
      k = 0;
      while (sb.phase == PH_MOVE && k < max_ticks) begin
         if (k < tt) a = a0 * (tt - k) / tt + rnd_span(4);
         else a = rnd_span(k > tt + 2 ? 0 : 64);
         send(1'b0, raw_for_angle(a), rnd_span(1 << 12), rnd_span(1000),
              rnd_span(1 << 20));
         k++;
      end
   endtask

   task automatic run_homing();
      int s, n;
      s = $urandom_range(0, 1000);
      send(1'b1, rnd_span(1 << 18), rnd_span(1 << 12), s, rnd_span(1 << 20));
      n = $urandom_range(0, 3);
      repeat (n) begin
         send(1'b0, rnd_span(1 << 18), rnd_span(1 << 16),
              ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, s), rnd_span(1 << 20));
      end
      if ($urandom_range(0, 9) == 0) send_noise(1'b0);
      if (sb.phase != PH_SEARCH) return;
      send(1'b0, rnd_span(1 << 18), rnd_span(1 << 16), s + $urandom_range(1, 50),
           rnd_span(1 << 19));
      send(1'b0, rnd_span(1 << 20), rnd_span(1 << 16), rnd_span(1000), rnd_span(1 << 20));
      track_ramp($urandom_range(0, 7) == 0 ? $urandom_range(1, 6) : 40);
      repeat ($urandom_range(0, 2)) send_noise(1'b0);
   endtask

   initial begin
      int start_count;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cfg_write(REG_MAX_CURRENT, 32'h7FFFFFFF);
      cfg_write(REG_RAMP_TICKS, 32'd4);
      send(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
      send(1'b1, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 32'sh7FFFFFFF);
      send(1'b0, 32'sd0, 32'sh80000000, -32'sd1, 32'sd0);
      send(1'b0, 32'sd0, 32'sh7FFFFFFF, -32'sd1, 32'sd0);
      send(1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sh7FFFFFFF);
      send(1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      track_ramp(2);
      send(1'b1, 32'sd4096, 32'sd0, 32'sd7, 32'sd0);
      send(1'b0, 32'sd0, 32'sd0, 32'sd7, 32'sd0);
      send(1'b0, 32'sd0, 32'sd100, 32'sd8, 32'sd300000);
      send(1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      track_ramp(12);
      send(1'b0, 32'sd12345, 32'sd0, 32'sd0, 32'sd0);
      run_homing();

      for (int ph = 0; items_sent < 1150; ph++) begin
         drain();
         configure((ph % 4 == 3) ? $urandom_range(32768, 131072) : 65536,
                   $urandom_range(16384, 262144), $urandom_range(0, 1),
                   32'h7FFFFFFF, ph % 2, rnd_span(1 << 20),
                   (ph % 8 == 2) ? 0 : (ph % 8 == 5) ? 65535 : $urandom_range(1, 12),
                   (ph % 8 == 3) ? 32'h7FFFFFFF : (ph % 8 == 4) ? 0
                                 : $urandom_range(0, 4096));
         start_count = items_sent;
         while (items_sent - start_count < ((ph % 8 == 5) ? 40 : 130)) begin
            if ($urandom_range(0, 9) == 0) send_noise(1'b0);
            else run_homing();
         end
      end

      drain();
      configure(32'h7FFFFFFF, 32'd1, 32'd1, 32'h7FFFFFFF, 32'd0, 32'h7FFFFFFF,
                32'd65535, 32'd0);
      repeat (60) send_noise(1'b1);
      drain();
      configure(32'd1, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd1, 32'h80000000, 32'd0,
                32'h7FFFFFFF);
      repeat (80) send_noise(1'b1);
      drain();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
